[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication helpers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define AST_IMPL(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define AST_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/bhpe_pkg.sv]
// ----------------------------------------------------------------------------
// bhpe_pkg
// Sizes, codes and transfer types of the binary heap priority engine.
// ----------------------------------------------------------------------------
package bhpe_pkg;

    localparam int DEPTH = 256;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int CH_W  = IDX_W + 2;
    localparam int KEY_W = 32;
    localparam int PAY_W = 16;

    localparam logic [1:0] K_APPEND = 2'd0;
    localparam logic [1:0] K_BUILD  = 2'd1;
    localparam logic [1:0] K_POP    = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] entry_key;
        logic [PAY_W-1:0] entry_payload;
    } in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] popped_key;
        logic [PAY_W-1:0] popped_payload;
        logic [CNT_W-1:0] entry_count;
    } out_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } entry_t;

endpackage

[sv/binary_heap_priority_engine_unit.sv]
// ----------------------------------------------------------------------------
// binary_heap_priority_engine_unit
// Array-held binary heap with append, bottom-up build and pop-root items.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): one transfer per item,
//   kind append, build or pop. item_stall is high while an item is at work.
//   result channel (result_valid / result_stall / result): one result per
//   item, held in an output register; the next item is taken while a result
//   waits there, and its own result waits in the sequencer until it drains.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): order_mode, written only
//   while idle; cfg_ready is high in the idle state.
// Sequence, from item transfer to result valid:
//   append and unused kind: go straight to the result stage.
//   pop: read the root, then the last entry, then sift that entry down,
//   reading the children and writing back per level; at most 7 levels.
//   build: sift each parent down in turn, from the last parent to the
//   root, in the same way as pop.
// All work goes through one compare unit and one single-port-read store,
// one read per cycle with registered read data; that port sets the rate.
// Reset clears the count, the order mode and the handshakes; the store
// itself is not cleared. A stalled result simply holds in its register.
// ----------------------------------------------------------------------------
module binary_heap_priority_engine_unit
    import bhpe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    output logic item_stall,
    input  in_t  item,
    output logic result_valid,
    input  logic result_stall,
    output out_t result,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_P_ROOT = 4'd1;
    localparam logic [3:0] S_P_LAST = 4'd2;
    localparam logic [3:0] S_B_NEXT = 4'd3;
    localparam logic [3:0] S_B_LOAD = 4'd4;
    localparam logic [3:0] S_SIFT_L = 4'd5;
    localparam logic [3:0] S_SIFT_R = 4'd6;
    localparam logic [3:0] S_SIFT_C = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             mode_reg, mode_next;
    logic [IDX_W-1:0] node_reg, node_next;
    logic [CNT_W-1:0] size_reg, size_next;
    logic [CNT_W-1:0] bidx_reg, bidx_next;
    logic             build_reg, build_next;
    entry_t           cur_reg, cur_next;
    entry_t           best_reg, best_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic             best_child_reg, best_child_next;
    out_t             res_reg, res_next;
    out_t             out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;

    logic [CH_W-1:0]  lc, rc;
    logic             lc_ok, rc_ok, pick_r;
    logic [KEY_W-1:0] cmp_b;
    logic             cmp_win;
    logic [CNT_W-1:0] last;
    logic [CNT_W-1:0] bidx_dec;

    function automatic logic beats(input logic mode, input logic [KEY_W-1:0] a,
                                   input logic [KEY_W-1:0] b);
        beats = mode ? (a < b) : (a > b);
    endfunction

    assign item_stall   = (state_reg != S_IDLE);
    assign cfg_ready    = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign lc       = {1'b0, node_reg, 1'b1};
    assign rc       = lc + CH_W'(1);
    assign lc_ok    = lc < {1'b0, size_reg};
    assign rc_ok    = rc < {1'b0, size_reg};
    // shared compare: left child against the moving entry, then right
    // child against the best so far
    assign cmp_b    = (state_reg == S_SIFT_C) ? best_reg.key : cur_reg.key;
    assign cmp_win  = beats(mode_reg, rd_data_reg.key, cmp_b);
    assign pick_r   = rc_ok && cmp_win;
    assign last     = count_reg - CNT_W'(1);
    assign bidx_dec = bidx_reg - CNT_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        mode_next       = mode_reg;
        node_next       = node_reg;
        size_next       = size_reg;
        bidx_next       = bidx_reg;
        build_next      = build_reg;
        cur_next        = cur_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        best_child_next = best_child_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && result_stall;
        we              = 1'b0;
        waddr           = node_reg;
        wdata           = cur_reg;
        raddr           = '0;

        if (cfg_valid && cfg_ready)
        begin
            mode_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    res_next = '{status: ST_DONE, popped_key: '0, popped_payload: '0,
                                 entry_count: count_reg};
                    state_next = S_DONE;
                    case (item.kind)
                        K_APPEND:
                        begin
                            if (count_reg >= CNT_W'(DEPTH))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                we                   = 1'b1;
                                waddr                = count_reg[IDX_W-1:0];
                                wdata                = '{key: item.entry_key,
                                                         payload: item.entry_payload};
                                count_next           = count_reg + CNT_W'(1);
                                res_next.entry_count = count_reg + CNT_W'(1);
                            end
                        end
                        K_BUILD:
                        begin
                            size_next  = count_reg;
                            bidx_next  = count_reg >> 1;
                            build_next = 1'b1;
                            state_next = S_B_NEXT;
                        end
                        K_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                raddr      = '0;
                                state_next = S_P_ROOT;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_P_ROOT:
            begin
                res_next.popped_key     = rd_data_reg.key;
                res_next.popped_payload = rd_data_reg.payload;
                raddr                   = last[IDX_W-1:0];
                state_next              = S_P_LAST;
            end
            S_P_LAST:
            begin
                cur_next             = rd_data_reg;
                count_next           = last;
                size_next            = last;
                node_next            = '0;
                build_next           = 1'b0;
                res_next.entry_count = last;
                state_next           = S_SIFT_L;
            end
            S_B_NEXT:
            begin
                if (bidx_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    raddr      = bidx_dec[IDX_W-1:0];
                    node_next  = bidx_dec[IDX_W-1:0];
                    bidx_next  = bidx_dec;
                    state_next = S_B_LOAD;
                end
            end
            S_B_LOAD:
            begin
                cur_next   = rd_data_reg;
                state_next = S_SIFT_L;
            end
            S_SIFT_L:
            begin
                if (lc_ok)
                begin
                    raddr      = lc[IDX_W-1:0];
                    state_next = S_SIFT_R;
                end
                else
                begin
                    we         = 1'b1;
                    state_next = build_reg ? S_B_NEXT : S_DONE;
                end
            end
            S_SIFT_R:
            begin
                if (cmp_win)
                begin
                    best_next       = rd_data_reg;
                    best_child_next = 1'b1;
                end
                else
                begin
                    best_next       = cur_reg;
                    best_child_next = 1'b0;
                end
                best_idx_next = lc[IDX_W-1:0];
                if (rc_ok)
                begin
                    raddr = rc[IDX_W-1:0];
                end
                state_next = S_SIFT_C;
            end
            S_SIFT_C:
            begin
                we = 1'b1;
                if (pick_r || best_child_reg)
                begin
                    wdata      = pick_r ? rd_data_reg : best_reg;
                    node_next  = pick_r ? rc[IDX_W-1:0] : best_idx_reg;
                    state_next = S_SIFT_L;
                end
                else
                begin
                    state_next = build_reg ? S_B_NEXT : S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            mode_reg      <= 1'b0;
            build_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            mode_reg      <= mode_next;
            build_reg     <= build_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg       <= node_next;
        size_reg       <= size_next;
        bidx_reg       <= bidx_next;
        cur_reg        <= cur_next;
        best_reg       <= best_next;
        best_idx_reg   <= best_idx_next;
        best_child_reg <= best_child_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

endmodule

[sv/bhpe_checker.sv]
// ----------------------------------------------------------------------------
// bhpe_checker
// Port-level checks of the heap engine, bound into the engine unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bhpe_checker
    import bhpe_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input logic item_stall,
    input logic result_valid,
    input logic result_stall,
    input out_t result
);

    `AST_NEXT(a_res_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))
    `AST_NEXT(a_busy_after_xfer, clk, rst_n, item_valid && !item_stall, item_stall)
    `AST_IMPL(a_count_range, clk, rst_n, result_valid, result.entry_count <= CNT_W'(DEPTH))
    `AST_IMPL(a_status_code, clk, rst_n, result_valid, result.status != ST_BAD)
    `AST_IMPL(a_reject_clean, clk, rst_n, result_valid && result.status != ST_DONE, result.popped_key == '0 && result.popped_payload == '0)

endmodule

bind binary_heap_priority_engine_unit bhpe_checker u_bhpe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

[bench/binary_heap_priority_engine_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_heap_priority_engine_unit_tb
// Self-checking bench for the heap engine. A queue-fed driver and a clocked
// monitor exchange transfers with random gaps and stalls. A predictor with
// its own heap copy produces the expected result for every accepted item.
// Directed corner items are followed by random phases under both orders.
// ----------------------------------------------------------------------------
module binary_heap_priority_engine_unit_tb;
    import bhpe_pkg::*;

    localparam logic [1:0] K_SPARE = 2'd3;
    localparam int RANDOM_OPS = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    in_t  item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    out_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data = 1'b0;

    binary_heap_priority_engine_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // heap copy used for prediction
    logic [KEY_W-1:0] heap_keys [DEPTH];
    logic [PAY_W-1:0] heap_tags [DEPTH];
    int               heap_count = 0;
    logic             heap_min_first = 1'b0;

    in_t  queued_ops [$];
    out_t predicted_results [$];
    int   ops_queued = 0;
    int   ops_taken = 0;
    int   gen_count = 0;
    int   errors = 0;
    bit   item_sent = 0;
    bit   res_sent = 0;
    bit   cfg_sent = 0;
    bit   no_idle = 0;
    int   send_gap = 0;
    int   stall_left = 0;

    function automatic bit key_beats(int a, int b);
        if (heap_min_first)
            return heap_keys[a] < heap_keys[b];
        return heap_keys[a] > heap_keys[b];
    endfunction

    function automatic void swap_entries(int a, int b);
        logic [KEY_W-1:0] k;
        logic [PAY_W-1:0] p;
        k = heap_keys[a];
        p = heap_tags[a];
        heap_keys[a] = heap_keys[b];
        heap_tags[a] = heap_tags[b];
        heap_keys[b] = k;
        heap_tags[b] = p;
    endfunction

    function automatic void sift_from(int node, int size);
        int best;
        int lc;
        int rc;
        bit done;
        done = 0;
        while (!done)
        begin
            best = node;
            lc = 2 * node + 1;
            rc = lc + 1;
            if (lc < size && key_beats(lc, best))
                best = lc;
            if (rc < size && key_beats(rc, best))
                best = rc;
            if (best == node)
                done = 1;
            else
            begin
                swap_entries(node, best);
                node = best;
            end
        end
    endfunction

    function automatic out_t predict_result(in_t req);
        out_t r;
        int last;
        r = '0;
        r.status = ST_DONE;
        case (req.kind)
            K_APPEND:
                if (heap_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    heap_keys[heap_count] = req.entry_key;
                    heap_tags[heap_count] = req.entry_payload;
                    heap_count++;
                end
            K_BUILD:
                for (int i = heap_count / 2; i > 0; i--)
                    sift_from(i - 1, heap_count);
            K_POP:
                if (heap_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    last = heap_count - 1;
                    swap_entries(0, last);
                    r.popped_key = heap_keys[last];
                    r.popped_payload = heap_tags[last];
                    heap_count = last;
                    sift_from(0, heap_count);
                end
            default: ;
        endcase
        r.entry_count = CNT_W'(heap_count);
        return r;
    endfunction

    // monitor: transfers are sampled at the rising edge
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n)
        begin
            item_sent = item_valid && !item_stall;
            res_sent = result_valid && !result_stall;
            cfg_sent = cfg_valid && cfg_ready;
            if (res_sent)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result with nothing expected: status %0d count %0d",
                           result.status, result.entry_count);
                    errors++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, result.status);
                        errors++;
                    end
                    if (result.popped_key !== want.popped_key)
                    begin
                        $error("popped_key: expected %h, actual %h",
                               want.popped_key, result.popped_key);
                        errors++;
                    end
                    if (result.popped_payload !== want.popped_payload)
                    begin
                        $error("popped_payload: expected %h, actual %h",
                               want.popped_payload, result.popped_payload);
                        errors++;
                    end
                    if (result.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.entry_count, result.entry_count);
                        errors++;
                    end
                end
            end
            if (cfg_sent)
                heap_min_first = cfg_data;
            if (item_sent)
            begin
                predicted_results.push_back(predict_result(item));
                ops_taken++;
            end
        end
    end

    // item driver
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_sent))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (queued_ops.size() > 0)
            begin
                item <= queued_ops.pop_front();
                item_valid <= 1'b1;
                send_gap = no_idle ? 0 : $urandom_range(0, 7);
            end
            else
                item_valid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_sent)
                stall_left = no_idle ? 0 : $urandom_range(0, 7);
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    task automatic add_op(logic [1:0] kind, logic [KEY_W-1:0] key, logic [PAY_W-1:0] tag);
        in_t op;
        op.kind = kind;
        op.entry_key = key;
        op.entry_payload = tag;
        queued_ops.push_back(op);
        ops_queued++;
        if (kind == K_APPEND && gen_count < DEPTH)
            gen_count++;
        else if (kind == K_POP && gen_count > 0)
            gen_count--;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (!(ops_taken == ops_queued && predicted_results.size() == 0))
            @(negedge clk);
    endtask

    task automatic set_order(logic v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        while (!cfg_sent)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return KEY_W'($urandom_range(0, 3));
            3: return {28'hFFFFFFF, 4'($urandom_range(0, 15))};
            default: return $urandom;
        endcase
    endfunction

    task automatic add_appends(int n);
        for (int i = 0; i < n; i++)
            add_op(K_APPEND, rand_key(), PAY_W'($urandom_range(0, 65535)));
    endtask

    task automatic add_pops(int n);
        for (int i = 0; i < n; i++)
            add_op(K_POP, $urandom, PAY_W'($urandom_range(0, 65535)));
    endtask

    task automatic add_sequence();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            add_appends($urandom_range(1, 24));
            add_op(K_BUILD, $urandom, PAY_W'($urandom));
            n = $urandom_range(0, 3) == 0 ? gen_count + 1 : $urandom_range(1, gen_count);
            add_pops(n);
        end
        else if (r < 50)
            add_appends($urandom_range(1, 30));
        else if (r < 63)
            add_pops($urandom_range(1, 10));
        else if (r < 70)
            add_op(K_BUILD, $urandom, PAY_W'($urandom));
        else if (r < 71)
        begin
            add_appends(DEPTH - gen_count + 2);
            add_op(K_BUILD, $urandom, PAY_W'($urandom));
        end
        else if (r < 78)
            add_pops(gen_count + 1);
        else
        begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                add_op(2'($urandom_range(0, 3)), $urandom, PAY_W'($urandom));
        end
    endtask

    initial
    begin
        int target;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // corners under the reset order: empty store, ties, key extremes
        add_op(K_POP, '1, '1);
        add_op(K_BUILD, '0, '0);
        add_op(K_SPARE, 32'h1234_5678, 16'hBEEF);
        add_op(K_APPEND, '0, '0);
        add_op(K_BUILD, '1, '1);
        add_op(K_APPEND, '1, '1);
        add_op(K_APPEND, 32'd5, 16'd1);
        add_op(K_APPEND, 32'd5, 16'd2);
        add_op(K_APPEND, 32'd5, 16'd3);
        add_op(K_APPEND, 32'hAAAA_5555, 16'h5A5A);
        add_op(K_APPEND, 32'h5555_AAAA, 16'hA5A5);
        add_op(K_BUILD, '0, '0);
        add_pops(7);
        add_op(K_POP, '0, '0);
        add_op(K_SPARE, '1, '1);
        wait_drained();

        // full store under min-first order, then drain it
        target = ops_queued + RANDOM_OPS;
        set_order(1'b1);
        add_appends(DEPTH + 2);
        add_op(K_BUILD, '0, '0);
        add_pops(gen_count + 1);

        while (ops_queued < target)
        begin
            set_order(1'($urandom_range(0, 1)));
            no_idle = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(3, 6))
                add_sequence();
        end
        set_order(1'b0);
        no_idle = 0;
        add_appends(20);
        add_op(K_BUILD, '0, '0);
        add_pops(gen_count + 1);

        wait_drained();
        repeat (40) @(negedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/bhpe_pkg.sv
sv/binary_heap_priority_engine_unit.sv
sv/bhpe_checker.sv
bench/binary_heap_priority_engine_unit_tb.sv
